FILE: hdl/efg_pkg.sv
// Event-flag group package: sizes, codes and transaction types.
package efg_pkg;

  localparam int NUM_FLAGS = 16;
  localparam int NUM_SLOTS = 16;
  localparam int FLAG_W    = $clog2(NUM_FLAGS);
  localparam int SLOT_W    = $clog2(NUM_SLOTS);

  typedef enum logic [2:0] {
    K_CREATE = 3'd0,
    K_DELETE = 3'd1,
    K_SET    = 3'd2,
    K_CLEAR  = 3'd3,
    K_PEND1  = 3'd4,
    K_PENDM  = 3'd5,
    K_CANCEL = 3'd6,
    K_UNUSED = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_LOCKED       = 3'd1,
    ST_INVALID      = 3'd2,
    ST_CREATE_FAIL  = 3'd3,
    ST_TASK_WAITING = 3'd4,
    ST_NOT_READY    = 3'd5,
    ST_WAITING      = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_ONE  = 2'd1,
    MODE_ANY  = 2'd2,
    MODE_ALL  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    OP_CHECK  = 3'd0,
    OP_DEL    = 3'd1,
    OP_SET    = 3'd2,
    OP_PEND   = 3'd3,
    OP_CANCEL = 3'd4
  } op_e;

  typedef struct packed {
    logic [2:0]        kind;
    logic [FLAG_W-1:0] flag_id;
    logic [15:0]       flag_mask;
    logic              wait_all;
    logic [SLOT_W-1:0] waiter_slot;
    logic              no_wait;
    logic              force_delete;
    logic              sched_locked;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  created_id;
    logic [15:0] wake_mask;
    logic [15:0] ready_flags;
  } res_t;

  // token passed cell to cell
  typedef struct packed {
    logic vld;
    op_e  op;
    logic busy;
  } link_t;

  // command fields seen by every cell
  typedef struct packed {
    logic [NUM_FLAGS-1:0] bit_m;
    logic [NUM_FLAGS-1:0] mask;
    mode_e                mode;
    logic [SLOT_W-1:0]    slot;
    logic [NUM_FLAGS-1:0] ready;
    logic                 clr;
  } bcast_t;

endpackage

FILE: hdl/efg_cell.sv
// One waiter slot cell: holds a slot's entry and acts as the sweep token passes.
module efg_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [efg_pkg::SLOT_W-1:0] idx_i,
  input  efg_pkg::bcast_t           bc_i,
  input  efg_pkg::link_t            link_i,
  output efg_pkg::link_t            link_o,
  output logic                      woke_o
);

  logic                          waiting_q, waiting_d;
  logic [efg_pkg::NUM_FLAGS-1:0] mask_q, mask_d;
  efg_pkg::mode_e                mode_q, mode_d;
  logic                          woke_q, woke_d;
  efg_pkg::link_t                link_q, link_d;
  logic                          hit_bit;
  logic                          sat;
  logic                          mine;

  assign hit_bit = waiting_q && ((mask_q & bc_i.bit_m) != '0);
  assign mine    = (idx_i == bc_i.slot);

  always_comb begin
    case (mode_q)
      efg_pkg::MODE_ALL: sat = ((mask_q & bc_i.ready) == mask_q);
      efg_pkg::MODE_ONE,
      efg_pkg::MODE_ANY: sat = ((mask_q & bc_i.ready) != '0);
      default:           sat = 1'b0;
    endcase
  end

  always_comb begin
    waiting_d = waiting_q;
    mask_d    = mask_q;
    mode_d    = mode_q;
    woke_d    = bc_i.clr ? 1'b0 : woke_q;
    link_d    = link_i;
    if (link_i.vld) begin
      case (link_i.op)
        efg_pkg::OP_CHECK: begin
          link_d.busy = link_i.busy | hit_bit;
        end
        efg_pkg::OP_DEL: begin
          if (hit_bit) begin
            if (mode_q == efg_pkg::MODE_ONE) begin
              waiting_d = 1'b0;
              mask_d    = '0;
              mode_d    = efg_pkg::MODE_NONE;
              woke_d    = 1'b1;
            end else begin
              mask_d = mask_q & ~bc_i.bit_m;
            end
          end
        end
        efg_pkg::OP_SET: begin
          if (waiting_q && sat) begin
            waiting_d = 1'b0;
            mask_d    = '0;
            mode_d    = efg_pkg::MODE_NONE;
            woke_d    = 1'b1;
          end
        end
        efg_pkg::OP_PEND: begin
          if (mine) begin
            waiting_d = 1'b1;
            mask_d    = bc_i.mask;
            mode_d    = bc_i.mode;
          end
        end
        efg_pkg::OP_CANCEL: begin
          if (mine && waiting_q) begin
            waiting_d = 1'b0;
            mask_d    = '0;
            mode_d    = efg_pkg::MODE_NONE;
            woke_d    = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q <= 1'b0;
      mask_q    <= '0;
      mode_q    <= efg_pkg::MODE_NONE;
      woke_q    <= 1'b0;
      link_q    <= '0;
    end else begin
      waiting_q <= waiting_d;
      mask_q    <= mask_d;
      mode_q    <= mode_d;
      woke_q    <= woke_d;
      link_q    <= link_d;
    end
  end

  assign link_o = link_q;
  assign woke_o = woke_q;

endmodule

FILE: hdl/event_flag_group_wait_table.sv
// Event-flag group top level: command decode, flag masks and the waiter cell chain.
//
// A command is taken at a rising edge with start_i high and busy_o low. Its
// single result appears on res_o for exactly one cycle with done_o high; the
// receiver cannot hold it off.
// Create, clear, refused and already-satisfied commands give their result in
// the cycle after the command.
// Set, pend and cancel send a token down the chain of 16 waiter cells, one
// cell per cycle; the result follows once the token leaves the last cell.
// Delete sweeps the chain for waiters on the flag; unless some are found and
// force_delete is low (ST_TASK_WAITING), it sweeps again to wake or strip them.
// busy_o is high while the chain is swept and low again in the result cycle, so
// the next command can be taken in the cycle its predecessor's result is shown.
// Reset clears the allocated and ready masks and every waiter entry; the
// block takes commands from the first cycle after reset is released.
module event_flag_group_wait_table (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  efg_pkg::cmd_t   cmd_i,
  output logic            busy_o,
  output logic            done_o,
  output efg_pkg::res_t   res_o
);

  localparam int NF = efg_pkg::NUM_FLAGS;
  localparam int NS = efg_pkg::NUM_SLOTS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SWEEP
  } state_e;

  state_e                 state_q;
  logic [NF-1:0]          alloc_q;
  logic [NF-1:0]          ready_q;
  logic [NF-1:0]          bit_q;
  logic [NF-1:0]          mask_q;
  efg_pkg::mode_e         mode_q;
  logic [efg_pkg::SLOT_W-1:0] slot_q;
  logic                   force_q;
  efg_pkg::op_e           op_q;
  logic                   launch_q;
  logic                   done_q;
  efg_pkg::res_t          res_q;

  efg_pkg::link_t         chain [NS+1];
  logic [NS-1:0]          woke;
  efg_pkg::bcast_t        bc;

  logic [NF-1:0]          in_bit;
  logic                   id_ok;
  logic                   free_found;
  logic [efg_pkg::FLAG_W-1:0] free_id;
  logic                   mask_bad;
  logic                   mask_met;

  assign in_bit   = NF'(1) << cmd_i.flag_id;
  assign id_ok    = alloc_q[cmd_i.flag_id];
  assign mask_bad = (cmd_i.flag_mask == '0) || ((cmd_i.flag_mask & ~alloc_q) != '0);
  assign mask_met = cmd_i.wait_all ? ((ready_q & cmd_i.flag_mask) == cmd_i.flag_mask)
                                   : ((ready_q & cmd_i.flag_mask) != '0);

  always_comb begin
    free_found = 1'b0;
    free_id    = '0;
    for (int i = NF - 1; i >= 0; i--) begin
      if (!alloc_q[i]) begin
        free_found = 1'b1;
        free_id    = efg_pkg::FLAG_W'(i);
      end
    end
  end

  assign bc.bit_m = bit_q;
  assign bc.mask  = mask_q;
  assign bc.mode  = mode_q;
  assign bc.slot  = slot_q;
  assign bc.ready = ready_q;
  assign bc.clr   = launch_q;

  assign chain[0].vld  = launch_q;
  assign chain[0].op   = op_q;
  assign chain[0].busy = 1'b0;

  for (genvar g = 0; g < NS; g++) begin : g_cell
    efg_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (efg_pkg::SLOT_W'(g)),
      .bc_i   (bc),
      .link_i (chain[g]),
      .link_o (chain[g+1]),
      .woke_o (woke[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      alloc_q  <= '0;
      ready_q  <= '0;
      bit_q    <= '0;
      mask_q   <= '0;
      mode_q   <= efg_pkg::MODE_NONE;
      slot_q   <= '0;
      force_q  <= 1'b0;
      op_q     <= efg_pkg::OP_CHECK;
      launch_q <= 1'b0;
      done_q   <= 1'b0;
      res_q    <= '0;
    end else begin
      launch_q <= 1'b0;
      done_q   <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            bit_q   <= in_bit;
            slot_q  <= cmd_i.waiter_slot;
            force_q <= cmd_i.force_delete;
            res_q.created_id <= '0;
            res_q.wake_mask  <= '0;
            res_q.status     <= efg_pkg::ST_OK;
            if (cmd_i.kind == efg_pkg::K_CREATE) begin
              done_q <= 1'b1;
              res_q.ready_flags <= ready_q;
              if (free_found) begin
                alloc_q <= alloc_q | (NF'(1) << free_id);
                res_q.created_id <= 4'(free_id);
              end else begin
                res_q.status <= efg_pkg::ST_CREATE_FAIL;
              end
            end else if (cmd_i.kind == efg_pkg::K_UNUSED) begin
              done_q <= 1'b1;
              res_q.status      <= efg_pkg::ST_INVALID;
              res_q.ready_flags <= ready_q;
            end else if (cmd_i.sched_locked) begin
              done_q <= 1'b1;
              res_q.status      <= efg_pkg::ST_LOCKED;
              res_q.ready_flags <= ready_q;
            end else begin
              res_q.ready_flags <= ready_q;
              case (cmd_i.kind)
                efg_pkg::K_DELETE: begin
                  if (!id_ok) begin
                    done_q <= 1'b1;
                    res_q.status <= efg_pkg::ST_INVALID;
                  end else begin
                    op_q     <= efg_pkg::OP_CHECK;
                    launch_q <= 1'b1;
                    state_q  <= S_CHECK;
                  end
                end
                efg_pkg::K_SET: begin
                  if (!id_ok) begin
                    done_q <= 1'b1;
                    res_q.status <= efg_pkg::ST_INVALID;
                  end else if ((ready_q & in_bit) != '0) begin
                    done_q <= 1'b1;
                  end else begin
                    ready_q  <= ready_q | in_bit;
                    op_q     <= efg_pkg::OP_SET;
                    launch_q <= 1'b1;
                    state_q  <= S_SWEEP;
                  end
                end
                efg_pkg::K_CLEAR: begin
                  done_q <= 1'b1;
                  if (!id_ok) begin
                    res_q.status <= efg_pkg::ST_INVALID;
                  end else begin
                    ready_q <= ready_q & ~in_bit;
                    res_q.ready_flags <= ready_q & ~in_bit;
                  end
                end
                efg_pkg::K_PEND1: begin
                  if (!id_ok) begin
                    done_q <= 1'b1;
                    res_q.status <= efg_pkg::ST_INVALID;
                  end else if ((ready_q & in_bit) != '0) begin
                    done_q <= 1'b1;
                  end else if (cmd_i.no_wait) begin
                    done_q <= 1'b1;
                    res_q.status <= efg_pkg::ST_NOT_READY;
                  end else begin
                    mask_q   <= in_bit;
                    mode_q   <= efg_pkg::MODE_ONE;
                    op_q     <= efg_pkg::OP_PEND;
                    launch_q <= 1'b1;
                    res_q.status <= efg_pkg::ST_WAITING;
                    state_q  <= S_SWEEP;
                  end
                end
                efg_pkg::K_PENDM: begin
                  if (mask_bad) begin
                    done_q <= 1'b1;
                    res_q.status <= efg_pkg::ST_INVALID;
                  end else if (mask_met) begin
                    done_q <= 1'b1;
                  end else if (cmd_i.no_wait) begin
                    done_q <= 1'b1;
                    res_q.status <= efg_pkg::ST_NOT_READY;
                  end else begin
                    mask_q   <= cmd_i.flag_mask;
                    mode_q   <= cmd_i.wait_all ? efg_pkg::MODE_ALL : efg_pkg::MODE_ANY;
                    op_q     <= efg_pkg::OP_PEND;
                    launch_q <= 1'b1;
                    res_q.status <= efg_pkg::ST_WAITING;
                    state_q  <= S_SWEEP;
                  end
                end
                default: begin
                  op_q     <= efg_pkg::OP_CANCEL;
                  launch_q <= 1'b1;
                  state_q  <= S_SWEEP;
                end
              endcase
            end
          end
        end
        S_CHECK: begin
          if (chain[NS].vld) begin
            if (chain[NS].busy && !force_q) begin
              done_q <= 1'b1;
              res_q.status <= efg_pkg::ST_TASK_WAITING;
              state_q <= S_IDLE;
            end else begin
              op_q     <= efg_pkg::OP_DEL;
              launch_q <= 1'b1;
              state_q  <= S_SWEEP;
            end
          end
        end
        S_SWEEP: begin
          if (chain[NS].vld) begin
            done_q <= 1'b1;
            res_q.wake_mask <= 16'(woke);
            state_q <= S_IDLE;
            if (op_q == efg_pkg::OP_DEL) begin
              alloc_q <= alloc_q & ~bit_q;
              ready_q <= ready_q & ~bit_q;
              res_q.ready_flags <= ready_q & ~bit_q;
            end else begin
              res_q.ready_flags <= ready_q;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

FILE: test/testbench.sv
// Testbench for event_flag_group_wait_table: directed and random commands checked against a predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  class flag_group_scoreboard;
    logic [efg_pkg::NUM_FLAGS-1:0] allocated;
    logic [efg_pkg::NUM_FLAGS-1:0] ready;
    logic                          waiting[efg_pkg::NUM_SLOTS];
    logic [efg_pkg::NUM_FLAGS-1:0] wait_mask[efg_pkg::NUM_SLOTS];
    efg_pkg::mode_e                wait_mode[efg_pkg::NUM_SLOTS];
    efg_pkg::res_t                 pending_results[$];
    int                            mismatches;

    function new();
      allocated  = '0;
      ready      = '0;
      mismatches = 0;
      for (int s = 0; s < efg_pkg::NUM_SLOTS; s++) begin
        waiting[s]   = 1'b0;
        wait_mask[s] = '0;
        wait_mode[s] = efg_pkg::MODE_NONE;
      end
    endfunction

    function void release_slot(int s);
      waiting[s]   = 1'b0;
      wait_mask[s] = '0;
      wait_mode[s] = efg_pkg::MODE_NONE;
    endfunction

    function bit slot_met(int s);
      if (wait_mode[s] == efg_pkg::MODE_ALL)
        return (wait_mask[s] & ready) == wait_mask[s];
      if (wait_mode[s] == efg_pkg::MODE_ONE || wait_mode[s] == efg_pkg::MODE_ANY)
        return (wait_mask[s] & ready) != '0;
      return 1'b0;
    endfunction

    function efg_pkg::res_t apply_command(efg_pkg::cmd_t c);
      efg_pkg::res_t                 r;
      logic [efg_pkg::NUM_FLAGS-1:0] b;
      logic                          id_ok;
      logic                          blocked;
      logic                          met;
      r = '0;
      r.status = efg_pkg::ST_OK;
      b = efg_pkg::NUM_FLAGS'(1) << c.flag_id;
      id_ok = (allocated & b) != '0;
      case (efg_pkg::kind_e'(c.kind))
        efg_pkg::K_CREATE: begin
          r.status = efg_pkg::ST_CREATE_FAIL;
          for (int s = 0; s < efg_pkg::NUM_FLAGS; s++) begin
            if (!allocated[s]) begin
              allocated[s] = 1'b1;
              r.created_id = 4'(s);
              r.status = efg_pkg::ST_OK;
              break;
            end
          end
        end
        efg_pkg::K_UNUSED: r.status = efg_pkg::ST_INVALID;
        default: begin
          if (c.sched_locked) begin
            r.status = efg_pkg::ST_LOCKED;
          end else begin
            case (efg_pkg::kind_e'(c.kind))
              efg_pkg::K_DELETE: begin
                if (!id_ok) begin
                  r.status = efg_pkg::ST_INVALID;
                end else begin
                  blocked = 1'b0;
                  for (int s = 0; s < efg_pkg::NUM_SLOTS; s++)
                    if (waiting[s] && (wait_mask[s] & b) != '0) blocked = 1'b1;
                  if (blocked && !c.force_delete) begin
                    r.status = efg_pkg::ST_TASK_WAITING;
                  end else begin
                    for (int s = 0; s < efg_pkg::NUM_SLOTS; s++) begin
                      if (waiting[s] && (wait_mask[s] & b) != '0) begin
                        if (wait_mode[s] == efg_pkg::MODE_ONE) begin
                          release_slot(s);
                          r.wake_mask[s] = 1'b1;
                        end else begin
                          wait_mask[s] &= ~b;
                        end
                      end
                    end
                    allocated &= ~b;
                    ready &= ~b;
                  end
                end
              end
              efg_pkg::K_SET: begin
                if (!id_ok) begin
                  r.status = efg_pkg::ST_INVALID;
                end else if ((ready & b) == '0) begin
                  ready |= b;
                  for (int s = 0; s < efg_pkg::NUM_SLOTS; s++) begin
                    if (waiting[s] && slot_met(s)) begin
                      release_slot(s);
                      r.wake_mask[s] = 1'b1;
                    end
                  end
                end
              end
              efg_pkg::K_CLEAR: begin
                if (!id_ok) r.status = efg_pkg::ST_INVALID;
                else ready &= ~b;
              end
              efg_pkg::K_PEND1: begin
                if (!id_ok) begin
                  r.status = efg_pkg::ST_INVALID;
                end else if ((ready & b) != '0) begin
                  r.status = efg_pkg::ST_OK;
                end else if (c.no_wait) begin
                  r.status = efg_pkg::ST_NOT_READY;
                end else begin
                  waiting[c.waiter_slot]   = 1'b1;
                  wait_mask[c.waiter_slot] = b;
                  wait_mode[c.waiter_slot] = efg_pkg::MODE_ONE;
                  r.status = efg_pkg::ST_WAITING;
                end
              end
              efg_pkg::K_PENDM: begin
                met = c.wait_all ? ((ready & c.flag_mask) == c.flag_mask)
                                 : ((ready & c.flag_mask) != '0);
                if (c.flag_mask == '0 || (c.flag_mask & ~allocated) != '0) begin
                  r.status = efg_pkg::ST_INVALID;
                end else if (met) begin
                  r.status = efg_pkg::ST_OK;
                end else if (c.no_wait) begin
                  r.status = efg_pkg::ST_NOT_READY;
                end else begin
                  waiting[c.waiter_slot]   = 1'b1;
                  wait_mask[c.waiter_slot] = c.flag_mask;
                  wait_mode[c.waiter_slot] = c.wait_all ? efg_pkg::MODE_ALL
                                                        : efg_pkg::MODE_ANY;
                  r.status = efg_pkg::ST_WAITING;
                end
              end
              default: begin
                if (waiting[c.waiter_slot]) begin
                  release_slot(c.waiter_slot);
                  r.wake_mask[c.waiter_slot] = 1'b1;
                end
              end
            endcase
          end
        end
      endcase
      r.ready_flags = ready;
      return r;
    endfunction

    function void note_command(efg_pkg::cmd_t c);
      pending_results.push_back(apply_command(c));
    endfunction

    function void check_result(efg_pkg::res_t got);
      efg_pkg::res_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d id %0d wake %h ready %h",
                   got.status, got.created_id, got.wake_mask, got.ready_flags);
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status || got.created_id !== want.created_id ||
          got.wake_mask !== want.wake_mask || got.ready_flags !== want.ready_flags) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected status %0d id %0d wake %h ready %h, got %0d %0d %h %h",
                   want.status, want.created_id, want.wake_mask, want.ready_flags,
                   got.status, got.created_id, got.wake_mask, got.ready_flags);
      end
    endfunction
  endclass

  logic          clk_i   = 1'b0;
  logic          rst_ni  = 1'b0;
  logic          start_i = 1'b0;
  efg_pkg::cmd_t cmd_i   = '0;
  logic          busy_o;
  logic          done_o;
  efg_pkg::res_t res_o;

  flag_group_scoreboard sb;

  event_flag_group_wait_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .cmd_i  (cmd_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(res_o);
      if (start_i && !busy_o) sb.note_command(cmd_i);
    end
  end

  function automatic efg_pkg::cmd_t build_cmd(efg_pkg::kind_e k, int id, int m, bit all,
                                              int slot, bit nw, bit frc, bit lock);
    efg_pkg::cmd_t c;
    c.kind         = k;
    c.flag_id      = efg_pkg::FLAG_W'(id);
    c.flag_mask    = 16'(m);
    c.wait_all     = all;
    c.waiter_slot  = efg_pkg::SLOT_W'(slot);
    c.no_wait      = nw;
    c.force_delete = frc;
    c.sched_locked = lock;
    return c;
  endfunction

  // mostly an allocated flag, now and then any id
  function automatic logic [efg_pkg::FLAG_W-1:0] pick_flag();
    logic [efg_pkg::FLAG_W-1:0] id;
    id = efg_pkg::FLAG_W'($urandom_range(0, efg_pkg::NUM_FLAGS - 1));
    if (sb.allocated != '0 && $urandom_range(0, 9) != 0)
      while (!sb.allocated[id])
        id = efg_pkg::FLAG_W'($urandom_range(0, efg_pkg::NUM_FLAGS - 1));
    return id;
  endfunction

  function automatic efg_pkg::cmd_t random_command(bit fill);
    efg_pkg::cmd_t c;
    int unsigned   rnd;
    int            r;
    int            create_w;
    int            del_w;
    int            n;
    logic [15:0]   m;
    rnd = $urandom;
    c = efg_pkg::cmd_t'(rnd[$bits(efg_pkg::cmd_t)-1:0]);
    create_w = fill ? 30 : 6;
    del_w    = fill ? 4 : 14;
    r = $urandom_range(0, 99);
    if (r < 2) c.kind = efg_pkg::K_UNUSED;
    else if (r < 2 + create_w) c.kind = efg_pkg::K_CREATE;
    else if (r < 2 + create_w + del_w) c.kind = efg_pkg::K_DELETE;
    else begin
      r = $urandom_range(0, 99);
      if (r < 28) c.kind = efg_pkg::K_SET;
      else if (r < 46) c.kind = efg_pkg::K_CLEAR;
      else if (r < 68) c.kind = efg_pkg::K_PEND1;
      else if (r < 88) c.kind = efg_pkg::K_PENDM;
      else c.kind = efg_pkg::K_CANCEL;
    end
    c.flag_id      = pick_flag();
    c.no_wait      = ($urandom_range(0, 4) == 0);
    c.sched_locked = ($urandom_range(0, 15) == 0);
    r = $urandom_range(0, 19);
    if (r == 0) begin
      m = 16'($urandom);
    end else if (r == 1) begin
      m = '0;
    end else begin
      m = '0;
      n = $urandom_range(1, 3);
      repeat (n) m |= 16'd1 << pick_flag();
    end
    c.flag_mask = m;
    return c;
  endfunction

  task automatic send(efg_pkg::cmd_t c, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    cmd_i   <= c;
    do @(posedge clk_i); while (busy_o);
  endtask

  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

  initial begin
    bit fill;
    bit burst;
    int drain;
    sb = new();
    fill  = 1'b0;
    burst = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    send(build_cmd(efg_pkg::K_UNUSED, 15, 16'hFFFF, 1, 15, 1, 1, 1), 0);
    send(build_cmd(efg_pkg::K_SET,     0, 0,        0, 0,  0, 0, 0), 0);
    send(build_cmd(efg_pkg::K_CREATE,  0, 0,        0, 0,  0, 0, 1), 0);
    send(build_cmd(efg_pkg::K_CREATE,  0, 0,        0, 0,  0, 0, 0), 0);
    send(build_cmd(efg_pkg::K_CREATE,  0, 0,        0, 0,  0, 0, 0), 1);
    send(build_cmd(efg_pkg::K_SET,     0, 0,        0, 0,  0, 0, 1), 0);
    send(build_cmd(efg_pkg::K_PEND1,   0, 0,        0, 0,  1, 0, 0), 0);
    send(build_cmd(efg_pkg::K_PEND1,   0, 0,        0, 0,  0, 0, 0), 1);
    send(build_cmd(efg_pkg::K_PENDM,   0, 16'h0000, 0, 1,  0, 0, 0), 0);
    send(build_cmd(efg_pkg::K_PENDM,   0, 16'h8000, 0, 1,  0, 0, 0), 0);
    send(build_cmd(efg_pkg::K_PENDM,   0, 16'h0006, 1, 1,  0, 0, 0), 0);
    send(build_cmd(efg_pkg::K_PENDM,   0, 16'h0003, 0, 15, 0, 0, 0), 1);
    send(build_cmd(efg_pkg::K_PEND1,   2, 0,        0, 2,  0, 0, 0), 0);
    send(build_cmd(efg_pkg::K_PEND1,   1, 0,        0, 2,  0, 0, 0), 0);
    send(build_cmd(efg_pkg::K_DELETE,  1, 0,        0, 0,  0, 0, 0), 0);
    send(build_cmd(efg_pkg::K_SET,     0, 0,        0, 0,  0, 0, 0), 1);
    send(build_cmd(efg_pkg::K_SET,     0, 0,        0, 0,  0, 0, 0), 0);
    send(build_cmd(efg_pkg::K_PEND1,   0, 0,        0, 3,  0, 0, 0), 0);
    send(build_cmd(efg_pkg::K_DELETE,  1, 0,        0, 0,  0, 1, 0), 0);
    send(build_cmd(efg_pkg::K_DELETE,  2, 0,        0, 0,  0, 1, 0), 1);
    send(build_cmd(efg_pkg::K_CLEAR,   0, 0,        0, 0,  0, 0, 0), 0);
    send(build_cmd(efg_pkg::K_SET,     0, 0,        0, 0,  0, 0, 0), 0);
    send(build_cmd(efg_pkg::K_CANCEL,  0, 0,        0, 5,  0, 0, 0), 0);
    send(build_cmd(efg_pkg::K_CLEAR,   0, 0,        0, 0,  0, 0, 0), 1);
    send(build_cmd(efg_pkg::K_PEND1,   0, 0,        0, 4,  0, 0, 0), 0);
    send(build_cmd(efg_pkg::K_CANCEL,  0, 0,        0, 4,  0, 0, 0), 0);

    for (int i = 0; i < 1650; i++) begin
      if (i % 150 == 0) fill = !fill;
      if ($urandom_range(0, 39) == 0) burst = !burst;
      send(random_command(fill), burst);
    end
    start_i <= 1'b0;

    @(posedge clk_i);
    drain = 0;
    while (sb.pending_results.size() != 0 && drain < 1000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (40) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
